### hdl/frame_pacing_stats_monitor_assert.svh
// Assertion macros for the frame pacing statistics monitor.
// Depends on nothing; included by frame_pacing_stats_monitor, the module that carries checks.
`ifndef FRAME_PACING_STATS_MONITOR_ASSERT_SVH
`define FRAME_PACING_STATS_MONITOR_ASSERT_SVH

`ifndef SYNTHESIS
`define FPSM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame pacing monitor check failed");
`define FPSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame pacing monitor check failed");
`else
`define FPSM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FPSM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hdl/fpsm_pkg.sv
// Shared types, constants and saturating helpers for the frame pacing monitor.
// No dependencies.
package fpsm_pkg;

  localparam int COUNTER_WIDTH = 32;
  localparam int OUT_W = 32;
  localparam int SLOT_W = 32;
  localparam int TIME_W = 32;
  localparam int BUDGET_W = 16;
  localparam int SUM_W = ((COUNTER_WIDTH > OUT_W) ? COUNTER_WIDTH : OUT_W) + 1;

  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_NOTE       = 2'd0,
    MODE_RUN_NORMAL = 2'd1,
    MODE_RUN_FADE   = 2'd2
  } mode_t;

  typedef struct packed {
    logic              note;
    logic              clear;
    logic [SLOT_W-1:0] slot;
  } bank_ctrl_t;

  typedef struct packed {
    logic [COUNTER_WIDTH-1:0] shown;
    logic [COUNTER_WIDTH-1:0] skipped;
  } bank_stat_t;

  function automatic logic [COUNTER_WIDTH-1:0] sat_add(
    input logic [COUNTER_WIDTH-1:0] count,
    input logic [OUT_W-1:0]         amount
  );
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(count) + SUM_W'(amount);
    if (sum > SUM_W'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return sum[COUNTER_WIDTH-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] report(input logic [COUNTER_WIDTH-1:0] count);
    logic [SUM_W-1:0] wide;
    wide = SUM_W'(count);
    if (wide > SUM_W'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return wide[OUT_W-1:0];
  endfunction

endpackage

### hdl/fpsm_if.sv
// Valid/ready channels for note words and statistics words.
// Depends on fpsm_pkg for field widths.
interface fpsm_note_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [fpsm_pkg::SLOT_W-1:0]   slot;
  logic [fpsm_pkg::TIME_W-1:0]   shown_time;
  logic [fpsm_pkg::TIME_W-1:0]   due_time;
  logic [fpsm_pkg::BUDGET_W-1:0] late_budget;
  logic                          fade_bank;

  modport source (output valid, mode, slot, shown_time, due_time, late_budget, fade_bank,
                  input ready);
  modport sink (input valid, mode, slot, shown_time, due_time, late_budget, fade_bank,
                output ready);
endinterface

interface fpsm_stats_if;
  logic                       valid;
  logic                       ready;
  logic [fpsm_pkg::OUT_W-1:0] shown_normal;
  logic [fpsm_pkg::OUT_W-1:0] skipped_normal;
  logic [fpsm_pkg::OUT_W-1:0] shown_fade;
  logic [fpsm_pkg::OUT_W-1:0] skipped_fade;
  logic [fpsm_pkg::OUT_W-1:0] missed_count;
  logic [fpsm_pkg::OUT_W-1:0] worst_lateness;

  modport source (output valid, shown_normal, skipped_normal, shown_fade, skipped_fade,
                  missed_count, worst_lateness, input ready);
  modport sink (input valid, shown_normal, skipped_normal, shown_fade, skipped_fade,
                missed_count, worst_lateness, output ready);
endinterface

### hdl/fpsm_bank.sv
// One counter bank: shown and skipped counts, previous slot and seen flag.
// Depends on fpsm_pkg.
module fpsm_bank (
  input  logic                 clk,
  input  logic                 rst,
  input  fpsm_pkg::bank_ctrl_t ctrl,
  output fpsm_pkg::bank_stat_t stat_next
);

  logic [fpsm_pkg::COUNTER_WIDTH-1:0] shown;
  logic [fpsm_pkg::COUNTER_WIDTH-1:0] skipped;
  logic [fpsm_pkg::SLOT_W-1:0]        prev_slot;
  logic                               seen;
  logic                               seen_next;
  logic [fpsm_pkg::SLOT_W:0]          expect_slot;
  logic [fpsm_pkg::SLOT_W:0]          gap;
  logic [fpsm_pkg::OUT_W-1:0]         skip_amount;

  always_comb begin
    expect_slot = {1'b0, prev_slot} + (fpsm_pkg::SLOT_W + 1)'(1);
    gap = {1'b0, ctrl.slot} - expect_slot;
    if (!seen) begin
      skip_amount = fpsm_pkg::OUT_W'(ctrl.slot);
    end else if ({1'b0, ctrl.slot} > expect_slot) begin
      skip_amount = gap[fpsm_pkg::OUT_W-1:0];
    end else begin
      skip_amount = '0;
    end

    stat_next.shown = shown;
    stat_next.skipped = skipped;
    seen_next = seen;
    if (ctrl.note) begin
      stat_next.shown = fpsm_pkg::sat_add(shown, fpsm_pkg::OUT_W'(1));
      stat_next.skipped = fpsm_pkg::sat_add(skipped, skip_amount);
      seen_next = 1'b1;
    end else if (ctrl.clear) begin
      seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown <= '0;
      skipped <= '0;
      prev_slot <= '0;
      seen <= 1'b0;
    end else begin
      shown <= stat_next.shown;
      skipped <= stat_next.skipped;
      seen <= seen_next;
      if (ctrl.note) begin
        prev_slot <= ctrl.slot;
      end
    end
  end

endmodule

### hdl/frame_pacing_stats_monitor.sv
// Frame pacing statistics monitor: input register, bank and lateness update, result register.
// Depends on fpsm_pkg, fpsm_if, fpsm_bank and frame_pacing_stats_monitor_assert.svh.
//
// Every accepted word (note, run-start or unused mode) yields one statistics word holding all
// counters after its update. The block takes one word per cycle sustained while the stats
// channel is ready; a word waits in the input register until it advances to the result
// register. The clock period is set by the bank update, a slot gap subtract followed by a
// saturating add and compare on the counter width. A new word is taken while a finished
// result still waits, since the input and result registers form two separate stages.
`include "frame_pacing_stats_monitor_assert.svh"

module frame_pacing_stats_monitor (
  input  logic             clk,
  input  logic             rst,
  fpsm_note_if.sink        notes,
  fpsm_stats_if.source     stats
);

  logic                          s1_valid;
  logic [1:0]                    s1_mode;
  logic [fpsm_pkg::SLOT_W-1:0]   s1_slot;
  logic [fpsm_pkg::TIME_W-1:0]   s1_displayed;
  logic [fpsm_pkg::TIME_W-1:0]   s1_deadline;
  logic [fpsm_pkg::BUDGET_W-1:0] s1_budget;
  logic                          s1_fade;

  logic                          out_valid;
  logic                          accept;
  logic                          advance;

  fpsm_pkg::bank_ctrl_t          normal_ctrl;
  fpsm_pkg::bank_ctrl_t          fade_ctrl;
  fpsm_pkg::bank_stat_t          normal_next;
  fpsm_pkg::bank_stat_t          fade_next;

  logic [fpsm_pkg::COUNTER_WIDTH-1:0] miss_total;
  logic [fpsm_pkg::COUNTER_WIDTH-1:0] miss_total_next;
  logic [fpsm_pkg::TIME_W-1:0]        lateness_peak;
  logic [fpsm_pkg::TIME_W-1:0]        lateness_peak_next;
  logic [fpsm_pkg::TIME_W-1:0]        late;
  logic                               is_note;

  assign advance = s1_valid && (!out_valid || stats.ready);
  assign notes.ready = !s1_valid || advance;
  assign accept = notes.valid && notes.ready;
  assign is_note = (s1_mode == fpsm_pkg::MODE_NOTE);

  always_comb begin
    normal_ctrl.slot = s1_slot;
    fade_ctrl.slot = s1_slot;
    normal_ctrl.note = advance && is_note && !s1_fade;
    fade_ctrl.note = advance && is_note && s1_fade;
    normal_ctrl.clear = advance && (s1_mode == fpsm_pkg::MODE_RUN_NORMAL);
    fade_ctrl.clear = advance && (s1_mode == fpsm_pkg::MODE_RUN_FADE);
  end

  fpsm_bank u_normal_bank (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (normal_ctrl),
    .stat_next (normal_next)
  );

  fpsm_bank u_fade_bank (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (fade_ctrl),
    .stat_next (fade_next)
  );

  always_comb begin
    late = (s1_displayed > s1_deadline) ? (s1_displayed - s1_deadline) : '0;
    miss_total_next = miss_total;
    lateness_peak_next = lateness_peak;
    if (is_note) begin
      if (late > lateness_peak) begin
        lateness_peak_next = late;
      end
      if ((s1_budget != '0) && (late >= fpsm_pkg::TIME_W'(s1_budget))) begin
        miss_total_next = fpsm_pkg::sat_add(miss_total, fpsm_pkg::OUT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
      miss_total <= '0;
      lateness_peak <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        miss_total <= miss_total_next;
        lateness_peak <= lateness_peak_next;
      end else if (stats.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the stage payload until it advances
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode <= notes.mode;
      s1_slot <= notes.slot;
      s1_displayed <= notes.shown_time;
      s1_deadline <= notes.due_time;
      s1_budget <= notes.late_budget;
      s1_fade <= notes.fade_bank;
    end
    if (advance) begin
      stats.shown_normal <= fpsm_pkg::report(normal_next.shown);
      stats.skipped_normal <= fpsm_pkg::report(normal_next.skipped);
      stats.shown_fade <= fpsm_pkg::report(fade_next.shown);
      stats.skipped_fade <= fpsm_pkg::report(fade_next.skipped);
      stats.missed_count <= fpsm_pkg::report(miss_total_next);
      stats.worst_lateness <= lateness_peak_next;
    end
  end

  assign stats.valid = out_valid;

  `FPSM_ASSERT_NEXT(a_peak_monotonic, clk, rst, !rst, lateness_peak >= $past(lateness_peak))
  `FPSM_ASSERT_NEXT(a_advance_fills_out, clk, rst, advance, out_valid)
  `FPSM_ASSERT_NEXT(a_state_holds_idle, clk, rst, !rst && !advance,
                    $stable(miss_total) && $stable(lateness_peak))
  `FPSM_ASSERT_IMPL(a_no_update_without_item, clk, rst, !s1_valid,
                    !normal_ctrl.note && !fade_ctrl.note && !normal_ctrl.clear && !fade_ctrl.clear)

endmodule

### tb/pacing_stats_checker.sv
// Checker for the frame pacing statistics monitor: tracks the per-bank frame tallies,
// predicts each statistics word and compares it with the block's output channel.
// Depends on fpsm_pkg and the fpsm_note_if / fpsm_stats_if interfaces.
module pacing_stats_checker (
  input  logic     clk,
  input  logic     rst,
  fpsm_note_if     notes,
  fpsm_stats_if    stats,
  output int       mismatches,
  output int       outstanding,
  output int       compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] CNT_CAP = (fpsm_pkg::COUNTER_WIDTH >= 64) ? {64{1'b1}} :
                                    ((64'd1 << fpsm_pkg::COUNTER_WIDTH) - 64'd1);
  localparam int NORMAL = 0;
  localparam int FADE = 1;

  typedef struct packed {
    logic [fpsm_pkg::OUT_W-1:0] shown_normal;
    logic [fpsm_pkg::OUT_W-1:0] skipped_normal;
    logic [fpsm_pkg::OUT_W-1:0] shown_fade;
    logic [fpsm_pkg::OUT_W-1:0] skipped_fade;
    logic [fpsm_pkg::OUT_W-1:0] missed_count;
    logic [fpsm_pkg::OUT_W-1:0] worst_lateness;
  } stats_word_t;

  logic [63:0]                 shown_tally [2];
  logic [63:0]                 skip_tally [2];
  logic [fpsm_pkg::SLOT_W-1:0] prev_slot [2];
  logic                        seen [2];
  logic [63:0]                 miss_tally;
  logic [fpsm_pkg::TIME_W-1:0] peak_late;
  stats_word_t                 expected_stats [$];

  initial begin
    mismatches = 0;
    outstanding = 0;
    compared = 0;
  end

  function automatic logic [63:0] bump(input logic [63:0] count, input logic [63:0] amount);
    if (count >= CNT_CAP || amount > CNT_CAP - count) begin
      return CNT_CAP;
    end
    return count + amount;
  endfunction

  function automatic logic [fpsm_pkg::OUT_W-1:0] clamp_out(input logic [63:0] count);
    return (count > 64'hFFFF_FFFF) ? {fpsm_pkg::OUT_W{1'b1}} : count[fpsm_pkg::OUT_W-1:0];
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 20) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic clear_tallies();
    for (int b = 0; b < 2; b++) begin
      shown_tally[b] = '0;
      skip_tally[b] = '0;
      prev_slot[b] = '0;
      seen[b] = 1'b0;
    end
    miss_tally = '0;
    peak_late = '0;
  endtask

  task automatic tally_word(output stats_word_t s);
    int b;
    logic [63:0] wide_slot;
    logic [63:0] after_last;
    logic [fpsm_pkg::TIME_W-1:0] late;
    case (notes.mode)
      fpsm_pkg::MODE_NOTE: begin
        b = notes.fade_bank ? FADE : NORMAL;
        wide_slot = 64'(notes.slot);
        after_last = 64'(prev_slot[b]) + 64'd1;
        if (!seen[b]) begin
          skip_tally[b] = bump(skip_tally[b], wide_slot);
        end else if (wide_slot > after_last) begin
          skip_tally[b] = bump(skip_tally[b], wide_slot - after_last);
        end
        prev_slot[b] = notes.slot;
        seen[b] = 1'b1;
        shown_tally[b] = bump(shown_tally[b], 64'd1);
        late = (notes.shown_time > notes.due_time) ?
               notes.shown_time - notes.due_time : '0;
        if (late > peak_late) begin
          peak_late = late;
        end
        if (notes.late_budget != '0 && late >= fpsm_pkg::TIME_W'(notes.late_budget)) begin
          miss_tally = bump(miss_tally, 64'd1);
        end
      end
      fpsm_pkg::MODE_RUN_NORMAL: seen[NORMAL] = 1'b0;
      fpsm_pkg::MODE_RUN_FADE: seen[FADE] = 1'b0;
      default: ;
    endcase
    s.shown_normal = clamp_out(shown_tally[NORMAL]);
    s.skipped_normal = clamp_out(skip_tally[NORMAL]);
    s.shown_fade = clamp_out(shown_tally[FADE]);
    s.skipped_fade = clamp_out(skip_tally[FADE]);
    s.missed_count = clamp_out(miss_tally);
    s.worst_lateness = peak_late;
  endtask

  task automatic compare_word(input stats_word_t got, input stats_word_t want);
    string tag;
    tag = $sformatf("word %0d", compared);
    if (got.shown_normal !== want.shown_normal)
      log_mismatch($sformatf("%s shown_normal %h, want %h", tag,
                             got.shown_normal, want.shown_normal));
    if (got.skipped_normal !== want.skipped_normal)
      log_mismatch($sformatf("%s skipped_normal %h, want %h", tag,
                             got.skipped_normal, want.skipped_normal));
    if (got.shown_fade !== want.shown_fade)
      log_mismatch($sformatf("%s shown_fade %h, want %h", tag,
                             got.shown_fade, want.shown_fade));
    if (got.skipped_fade !== want.skipped_fade)
      log_mismatch($sformatf("%s skipped_fade %h, want %h", tag,
                             got.skipped_fade, want.skipped_fade));
    if (got.missed_count !== want.missed_count)
      log_mismatch($sformatf("%s missed_count %h, want %h", tag,
                             got.missed_count, want.missed_count));
    if (got.worst_lateness !== want.worst_lateness)
      log_mismatch($sformatf("%s worst_lateness %h, want %h", tag,
                             got.worst_lateness, want.worst_lateness));
  endtask

  always @(posedge clk) begin
    stats_word_t want;
    stats_word_t got;
    if (rst) begin
      clear_tallies();
      expected_stats.delete();
    end else begin
      if (notes.valid && notes.ready) begin
        tally_word(want);
        expected_stats.push_back(want);
      end
      if (stats.valid && stats.ready) begin
        got.shown_normal = stats.shown_normal;
        got.skipped_normal = stats.skipped_normal;
        got.shown_fade = stats.shown_fade;
        got.skipped_fade = stats.skipped_fade;
        got.missed_count = stats.missed_count;
        got.worst_lateness = stats.worst_lateness;
        if (expected_stats.size() == 0) begin
          log_mismatch("statistics word with nothing pending");
        end else begin
          compare_word(got, expected_stats.pop_front());
        end
        compared++;
      end
    end
    outstanding = expected_stats.size();
  end

endmodule

### tb/frame_pacing_stats_monitor_tb.sv
// Top of the frame pacing monitor testbench: clock, reset, note word stimulus and verdict.
// Depends on fpsm_pkg, the fpsm interfaces, the monitor RTL and pacing_stats_checker.
module frame_pacing_stats_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int PHASE_WORDS = 443;

  typedef struct {
    logic [1:0]                    mode;
    logic [fpsm_pkg::SLOT_W-1:0]   slot;
    logic [fpsm_pkg::TIME_W-1:0]   shown_at;
    logic [fpsm_pkg::TIME_W-1:0]   due_at;
    logic [fpsm_pkg::BUDGET_W-1:0] budget;
    logic                          fade;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int src_idle_pct = 23;
  int snk_idle_pct = 66;
  int notes_sent = 0;
  int runs_sent = 0;
  int unused_sent = 0;
  int mismatches;
  int outstanding;
  int compared;
  int unsigned cycle_count = 0;

  fpsm_note_if notes_if ();
  fpsm_stats_if stats_if ();

  frame_pacing_stats_monitor uut (
    .clk   (clk),
    .rst   (rst),
    .notes (notes_if),
    .stats (stats_if)
  );

  pacing_stats_checker chk (
    .clk         (clk),
    .rst         (rst),
    .notes       (notes_if),
    .stats       (stats_if),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    stats_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      stats_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  function automatic frame_word_t fw(input logic [1:0] mode, input logic [31:0] slot,
                                     input logic [31:0] shown_at, input logic [31:0] due_at,
                                     input logic [31:0] budget, input logic [31:0] fade);
    frame_word_t w;
    w.mode = mode;
    w.slot = slot;
    w.shown_at = shown_at;
    w.due_at = due_at;
    w.budget = budget[fpsm_pkg::BUDGET_W-1:0];
    w.fade = fade[0];
    return w;
  endfunction

  task automatic send_word(input frame_word_t w);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      notes_if.valid <= 1'b0;
      @(negedge clk);
    end
    notes_if.valid <= 1'b1;
    notes_if.mode <= w.mode;
    notes_if.slot <= w.slot;
    notes_if.shown_time <= w.shown_at;
    notes_if.due_time <= w.due_at;
    notes_if.late_budget <= w.budget;
    notes_if.fade_bank <= w.fade;
    do @(posedge clk); while (!notes_if.ready);
    case (w.mode) inside
      fpsm_pkg::MODE_NOTE: notes_sent++;
      fpsm_pkg::MODE_RUN_NORMAL, fpsm_pkg::MODE_RUN_FADE: runs_sent++;
      default: unused_sent++;
    endcase
    @(negedge clk);
  endtask

  task automatic send_noise(input bit full_range);
    send_word(fw(2'($urandom_range(0, 3)),
                 full_range ? $urandom : $urandom_range(0, 255),
                 full_range ? $urandom : $urandom_range(0, 100_000),
                 full_range ? $urandom : $urandom_range(0, 100_000),
                 $urandom, $urandom));
  endtask

  task automatic play_run(inout int sent);
    int unsigned bank;
    int unsigned b;
    int unsigned len;
    int unsigned roll;
    int jitter;
    logic [31:0] slot_now [2];
    logic [31:0] base;
    logic [31:0] due;
    bank = $urandom_range(0, 1);
    send_word(fw(bank ? fpsm_pkg::MODE_RUN_FADE : fpsm_pkg::MODE_RUN_NORMAL,
                 $urandom, $urandom, $urandom, $urandom, $urandom));
    sent++;
    slot_now[0] = $urandom_range(0, 3);
    slot_now[1] = $urandom_range(0, 3);
    base = $urandom_range(100, 5000);
    len = $urandom_range(1, 12);
    repeat (len) begin
      b = ($urandom_range(0, 9) == 0) ? 1 - bank : bank;
      due = slot_now[b] * 33 + base;
      jitter = int'($urandom_range(0, 80)) - 20;
      send_word(fw(fpsm_pkg::MODE_NOTE, slot_now[b], due + jitter, due,
                   ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40), b));
      sent++;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        slot_now[b] += 1;
      end else if (roll < 85) begin
        slot_now[b] += $urandom_range(2, 6);
      end else if (roll >= 95) begin
        slot_now[b] -= $urandom_range(1, 3);
      end
    end
  endtask

  task automatic random_phase(input bit full_range, input int quota);
    int sent;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 99) < 15) begin
        send_noise(full_range);
        sent++;
      end else begin
        play_run(sent);
      end
    end
  endtask

  initial begin
    notes_if.valid = 1'b0;
    notes_if.mode = fpsm_pkg::MODE_NOTE;
    notes_if.slot = '0;
    notes_if.shown_time = '0;
    notes_if.due_time = '0;
    notes_if.late_budget = '0;
    notes_if.fade_bank = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(fw(fpsm_pkg::MODE_NOTE, 0, 10, 10, 0, 0));
    send_word(fw(fpsm_pkg::MODE_NOTE, 1, 20, 15, 5, 0));
    send_word(fw(fpsm_pkg::MODE_NOTE, 5, 30, 40, 1, 0));
    send_word(fw(fpsm_pkg::MODE_NOTE, 5, 50, 45, 6, 0));
    send_word(fw(fpsm_pkg::MODE_NOTE, 2, 64, 60, 5, 0));
    send_word(fw(fpsm_pkg::MODE_NOTE, 7, 200, 100, 16'hFFFF, 1));
    send_word(fw(fpsm_pkg::MODE_NOTE, 8, 400, 200, 0, 1));
    send_word(fw(fpsm_pkg::MODE_RUN_NORMAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 16'hFFFF, 1));
    send_word(fw(fpsm_pkg::MODE_NOTE, 3, 10, 10, 0, 0));
    send_word(fw(fpsm_pkg::MODE_RUN_FADE, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 16'hFFFF, 0));
    send_word(fw(fpsm_pkg::MODE_NOTE, 0, 12, 11, 1, 1));
    send_word(fw(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 16'hFFFF, 1));
    send_word(fw(fpsm_pkg::MODE_NOTE, 4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0));
    send_word(fw(fpsm_pkg::MODE_NOTE, 5, 0, 32'hFFFF_FFFF, 1, 0));
    send_word(fw(fpsm_pkg::MODE_NOTE, 1, 1000, 0, 1000, 1));
    send_word(fw(fpsm_pkg::MODE_NOTE, 2, 1000, 0, 1001, 1));

    random_phase(1'b0, PHASE_WORDS);
    src_idle_pct = 66;
    snk_idle_pct = 23;
    random_phase(1'b0, PHASE_WORDS);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_phase(1'b1, PHASE_WORDS);

    send_word(fw(fpsm_pkg::MODE_RUN_NORMAL, 0, 0, 0, 0, 0));
    send_word(fw(fpsm_pkg::MODE_NOTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 16'hFFFF, 0));
    send_word(fw(fpsm_pkg::MODE_NOTE, 0, 5, 5, 0, 0));
    send_word(fw(fpsm_pkg::MODE_RUN_FADE, 0, 0, 0, 0, 1));
    send_word(fw(fpsm_pkg::MODE_NOTE, 32'hFFFF_FFFF, 3, 2, 1, 1));
    send_word(fw(fpsm_pkg::MODE_RUN_FADE, 0, 0, 0, 0, 1));
    send_word(fw(fpsm_pkg::MODE_NOTE, 32'hFFFF_FFFF, 3, 2, 1, 1));
    send_word(fw(fpsm_pkg::MODE_NOTE, 32'hFFFF_FFFF, 3, 2, 1, 1));
    notes_if.valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("sent %0d frame notes, %0d run starts, %0d unused-mode words",
             notes_sent, runs_sent, unused_sent);
    $display("compared %0d statistics words across three stall patterns, %0d mismatches",
             compared, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/fpsm_pkg.sv
hdl/fpsm_if.sv
hdl/fpsm_bank.sv
hdl/frame_pacing_stats_monitor.sv
tb/pacing_stats_checker.sv
tb/frame_pacing_stats_monitor_tb.sv
